// File: hw/rtl/rers_pkg.sv
package rers_pkg;

	typedef enum logic [1:0] {
		ST_STOWED     = 2'd0,
		ST_EXTENDING  = 2'd1,
		ST_EXTENDED   = 2'd2,
		ST_RETRACTING = 2'd3
	} arm_state_t;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_EXTEND  = 2'd1,
		MODE_RETRACT = 2'd2
	} drive_mode_t;

	typedef enum logic [1:0] {
		REQ_TICK    = 2'd0,
		REQ_COMMAND = 2'd1,
		REQ_PAUSE   = 2'd2,
		REQ_RESET   = 2'd3
	} req_code_t;

	typedef enum logic [1:0] {
		CMD_EXTEND    = 2'd0,
		CMD_RETRACT   = 2'd1,
		CMD_STOW      = 2'd2,
		CMD_STOW_ALT  = 2'd3
	} cmd_code_t;

	localparam int unsigned AddrWidth = 5;
	localparam int unsigned DataWidth = 32;
	localparam int unsigned IndexWidth = 3;

	typedef enum logic [IndexWidth-1:0] {
		REG_EXTEND_TIMEOUT  = 3'd0,
		REG_RETRACT_TIMEOUT = 3'd1,
		REG_DETECT_THRESH   = 3'd2,
		REG_MOTOR_DUTY      = 3'd3,
		REG_SENSOR_ENABLE   = 3'd4
	} reg_index_t;

	localparam logic [31:0] ExtendTimeoutReset  = 32'd1000;
	localparam logic [31:0] RetractTimeoutReset = 32'd2000;
	localparam logic [15:0] DetectThreshReset   = 16'd100;
	localparam logic [7:0]  MotorDutyReset      = 8'd128;

	typedef struct packed {
		logic [31:0] extend_timeout;
		logic [31:0] retract_timeout;
		logic [15:0] detect_thresh;
		logic [7:0]  motor_duty;
		logic        sensor_enable;
	} cfg_t;

	typedef struct packed {
		req_code_t   req;
		cmd_code_t   cmd;
		logic [15:0] elapsed;
		logic        home_level;
		logic        range_ready;
		logic [15:0] range_sample;
	} request_t;

	typedef struct packed {
		arm_state_t  arm_state;
		logic        pending_valid;
		cmd_code_t   pending_cmd;
		drive_mode_t mode;
		logic [31:0] timer;
		logic [15:0] distance;
		logic        detect;
		logic [31:0] extend_cnt;
		logic [31:0] retract_cnt;
	} seq_state_t;

endpackage

// File: hw/rtl/rers_cfg_regs.sv
module rers_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rers_pkg::AddrWidth-1:0]    paddr,
	input  logic [rers_pkg::DataWidth-1:0]    pwdata,
	output logic [rers_pkg::DataWidth-1:0]    prdata,
	output logic                              pready,
	output rers_pkg::cfg_t                    cfg
);

	rers_pkg::cfg_t   cfg_q;
	rers_pkg::reg_index_t index;
	logic             wr_en;

	// Registers sit on word boundaries, so the low two address bits are ignored.
	assign index = rers_pkg::reg_index_t'(paddr[rers_pkg::AddrWidth-1:2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.extend_timeout  <= rers_pkg::ExtendTimeoutReset;
			cfg_q.retract_timeout <= rers_pkg::RetractTimeoutReset;
			cfg_q.detect_thresh   <= rers_pkg::DetectThreshReset;
			cfg_q.motor_duty      <= rers_pkg::MotorDutyReset;
			cfg_q.sensor_enable   <= 1'b0;
		end else if (wr_en) begin
			case (index)
				rers_pkg::REG_EXTEND_TIMEOUT:  cfg_q.extend_timeout  <= pwdata;
				rers_pkg::REG_RETRACT_TIMEOUT: cfg_q.retract_timeout <= pwdata;
				rers_pkg::REG_DETECT_THRESH:   cfg_q.detect_thresh   <= pwdata[15:0];
				rers_pkg::REG_MOTOR_DUTY:      cfg_q.motor_duty      <= pwdata[7:0];
				rers_pkg::REG_SENSOR_ENABLE:   cfg_q.sensor_enable   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (index)
			rers_pkg::REG_EXTEND_TIMEOUT:  prdata = cfg_q.extend_timeout;
			rers_pkg::REG_RETRACT_TIMEOUT: prdata = cfg_q.retract_timeout;
			rers_pkg::REG_DETECT_THRESH:   prdata = {16'd0, cfg_q.detect_thresh};
			rers_pkg::REG_MOTOR_DUTY:      prdata = {24'd0, cfg_q.motor_duty};
			rers_pkg::REG_SENSOR_ENABLE:   prdata = {31'd0, cfg_q.sensor_enable};
			default:                       prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/rers_step.sv
module rers_step (
	input  rers_pkg::cfg_t       cfg,
	input  rers_pkg::request_t   req,
	input  rers_pkg::seq_state_t cur,
	output rers_pkg::seq_state_t nxt
);

	// Entering a different state restarts the time in state.
	function automatic rers_pkg::seq_state_t go_to(rers_pkg::seq_state_t s,
			rers_pkg::arm_state_t target);
		rers_pkg::seq_state_t r;
		r = s;
		if (r.arm_state != target) begin
			r.arm_state = target;
			r.timer = '0;
		end
		return r;
	endfunction

	logic [32:0] timer_sum;

	assign timer_sum = {1'b0, cur.timer} + {17'd0, req.elapsed};

	always_comb begin
		nxt = cur;
		unique case (req.req)
			rers_pkg::REQ_TICK: begin
				nxt.timer = timer_sum[32] ? '1 : timer_sum[31:0];
				if (!cfg.sensor_enable) begin
					nxt.distance = '0;
					nxt.detect = 1'b0;
				end else if (req.range_ready) begin
					nxt.distance = req.range_sample;
				end
				if (cur.pending_valid) begin
					unique case (cur.pending_cmd)
						rers_pkg::CMD_EXTEND: begin
							if (nxt.arm_state == rers_pkg::ST_STOWED) begin
								nxt = go_to(nxt, rers_pkg::ST_EXTENDING);
							end
						end
						rers_pkg::CMD_RETRACT: begin
							if (nxt.arm_state == rers_pkg::ST_EXTENDED ||
									nxt.arm_state == rers_pkg::ST_EXTENDING) begin
								nxt = go_to(nxt, rers_pkg::ST_RETRACTING);
							end
						end
						default: begin
							nxt.mode = rers_pkg::MODE_OFF;
							nxt = go_to(nxt, rers_pkg::ST_STOWED);
						end
					endcase
					nxt.pending_valid = 1'b0;
				end
				unique case (nxt.arm_state)
					rers_pkg::ST_STOWED: begin
						nxt.mode = rers_pkg::MODE_OFF;
					end
					rers_pkg::ST_EXTENDING: begin
						nxt.mode = rers_pkg::MODE_EXTEND;
						if (nxt.timer >= cfg.extend_timeout) begin
							nxt.extend_cnt = nxt.extend_cnt + 32'd1;
							nxt = go_to(nxt, rers_pkg::ST_EXTENDED);
						end
					end
					rers_pkg::ST_EXTENDED: begin
						nxt.mode = rers_pkg::MODE_OFF;
						nxt.detect = cfg.sensor_enable && (nxt.distance < cfg.detect_thresh)
							&& (nxt.distance != '0);
					end
					rers_pkg::ST_RETRACTING: begin
						if (!req.home_level) begin
							nxt.mode = rers_pkg::MODE_OFF;
							nxt.retract_cnt = nxt.retract_cnt + 32'd1;
							nxt = go_to(nxt, rers_pkg::ST_STOWED);
						end else begin
							nxt.mode = rers_pkg::MODE_RETRACT;
							if (nxt.timer >= cfg.retract_timeout) begin
								nxt.retract_cnt = nxt.retract_cnt + 32'd1;
								nxt = go_to(nxt, rers_pkg::ST_STOWED);
							end
						end
					end
				endcase
			end
			rers_pkg::REQ_COMMAND: begin
				unique case (req.cmd)
					rers_pkg::CMD_EXTEND: begin
						if (cur.arm_state == rers_pkg::ST_STOWED ||
								cur.arm_state == rers_pkg::ST_EXTENDED) begin
							nxt.pending_cmd = rers_pkg::CMD_EXTEND;
							nxt.pending_valid = 1'b1;
						end
					end
					rers_pkg::CMD_RETRACT: begin
						if (cur.arm_state == rers_pkg::ST_EXTENDED ||
								cur.arm_state == rers_pkg::ST_EXTENDING) begin
							nxt.pending_cmd = rers_pkg::CMD_RETRACT;
							nxt.pending_valid = 1'b1;
						end
					end
					default: begin
						nxt.pending_cmd = rers_pkg::CMD_STOW;
						nxt.pending_valid = 1'b1;
					end
				endcase
			end
			rers_pkg::REQ_PAUSE: begin
				nxt.mode = rers_pkg::MODE_OFF;
				nxt = go_to(nxt, rers_pkg::ST_STOWED);
			end
			rers_pkg::REQ_RESET: begin
				nxt.mode = rers_pkg::MODE_OFF;
				nxt = go_to(nxt, rers_pkg::ST_STOWED);
				nxt.pending_valid = 1'b0;
				nxt.extend_cnt = '0;
				nxt.retract_cnt = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/rack_extend_retract_sequencer.sv
// Rack extend/retract sequencer. Each request beat (update tick, command, pause or reset)
// yields exactly one result beat carrying the arm state, motor mode, direction and duty,
// the object detection flag, the last range sample, both move counters and the time in
// the current state. A request beat is first captured in an input register. When it
// advances, the sequencer logic updates the state registers and loads the result
// register, which drives the outputs. The block takes one request beat every cycle
// while the result side is not stalled: the only feedback path is the state register
// update, built around a 33-bit timer add feeding two 32-bit timeout compares. The
// input side stalls only while the input register holds a beat and the result
// register is full and stalled. Commands are only latched in a pending slot and act
// on the next update tick, unless a reset request clears the slot first. Configuration
// registers sit on the APB port at word addresses 0x00 extend timeout, 0x04 retract
// timeout, 0x08 detect threshold, 0x0C motor duty and 0x10 range sensor enable; write
// them only while no beat is in flight. No clearing pass is needed after reset.
module rack_extend_retract_sequencer (
	input  logic                           clk,
	input  logic                           arst_n,
	// Request channel
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [1:0]                     req_type,
	input  logic [1:0]                     command_code,
	input  logic [15:0]                    elapsed_ms,
	input  logic                           home_switch_level,
	input  logic                           range_ready,
	input  logic [15:0]                    range_sample_mm,
	// Result channel
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [1:0]                     bridge_state,
	output logic [1:0]                     motor_mode,
	output logic                           motor_direction,
	output logic [7:0]                     motor_pwm,
	output logic                           object_detected,
	output logic [15:0]                    distance_mm,
	output logic [31:0]                    extend_total,
	output logic [31:0]                    retract_total,
	output logic [31:0]                    state_time_ms,
	// Configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rers_pkg::AddrWidth-1:0] paddr,
	input  logic [rers_pkg::DataWidth-1:0] pwdata,
	output logic [rers_pkg::DataWidth-1:0] prdata,
	output logic                           pready
);

	rers_pkg::cfg_t       cfg;
	rers_pkg::request_t   req_s1;
	logic                 valid_s1;
	rers_pkg::seq_state_t state_q;
	rers_pkg::seq_state_t state_nxt;
	logic                 advance;
	logic                 req_accept;

	logic [1:0]           bridge_state_q;
	logic [1:0]           motor_mode_q;
	logic                 motor_direction_q;
	logic [7:0]           motor_pwm_q;
	logic                 object_detected_q;
	logic [15:0]          distance_mm_q;
	logic [31:0]          extend_total_q;
	logic [31:0]          retract_total_q;
	logic [31:0]          state_time_q;
	logic                 rsp_valid_q;

	logic                 direction_d;
	logic [7:0]           pwm_d;

	rers_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The captured beat moves on whenever the result register is empty or draining.
	assign advance    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = valid_s1 && !advance;
	assign req_accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1.req          <= rers_pkg::req_code_t'(req_type);
			req_s1.cmd          <= rers_pkg::cmd_code_t'(command_code);
			req_s1.elapsed      <= elapsed_ms;
			req_s1.home_level   <= home_switch_level;
			req_s1.range_ready  <= range_ready;
			req_s1.range_sample <= range_sample_mm;
		end
	end

	rers_step u_step (
		.cfg (cfg),
		.req (req_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.arm_state     <= rers_pkg::ST_STOWED;
			state_q.pending_valid <= 1'b0;
			state_q.pending_cmd   <= rers_pkg::CMD_EXTEND;
			state_q.mode          <= rers_pkg::MODE_OFF;
			state_q.timer         <= '0;
			state_q.distance      <= '0;
			state_q.detect        <= 1'b0;
			state_q.extend_cnt    <= '0;
			state_q.retract_cnt   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Motor pins follow from the updated drive mode.
	always_comb begin
		direction_d = (state_nxt.mode == rers_pkg::MODE_EXTEND);
		pwm_d = (state_nxt.mode == rers_pkg::MODE_OFF) ? 8'd0 : cfg.motor_duty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bridge_state_q    <= state_nxt.arm_state;
			motor_mode_q      <= state_nxt.mode;
			motor_direction_q <= direction_d;
			motor_pwm_q       <= pwm_d;
			object_detected_q <= state_nxt.detect;
			distance_mm_q     <= state_nxt.distance;
			extend_total_q    <= state_nxt.extend_cnt;
			retract_total_q   <= state_nxt.retract_cnt;
			state_time_q      <= state_nxt.timer;
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign bridge_state     = bridge_state_q;
	assign motor_mode       = motor_mode_q;
	assign motor_direction  = motor_direction_q;
	assign motor_pwm        = motor_pwm_q;
	assign object_detected  = object_detected_q;
	assign distance_mm      = distance_mm_q;
	assign extend_total     = extend_total_q;
	assign retract_total    = retract_total_q;
	assign state_time_ms    = state_time_q;

`ifndef SYNTHESIS
	// The sequencer state only moves when a beat is processed.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("sequencer state changed without a processed beat");

	// A reset request leaves both move counters cleared in its result.
	a_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.req == rers_pkg::REQ_RESET |=>
			extend_total == 32'd0 && retract_total == 32'd0)
		else $error("reset request did not clear the move counters");

	// Motor pins in a result agree with its motor mode.
	a_motor_pins: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (motor_direction == (motor_mode == rers_pkg::MODE_EXTEND)) &&
			(motor_mode != rers_pkg::MODE_OFF || motor_pwm == 8'd0))
		else $error("motor pins disagree with motor mode");

	// An extending arm always drives the motor outward.
	a_extending_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.arm_state == rers_pkg::ST_EXTENDING |-> state_q.mode == rers_pkg::MODE_EXTEND)
		else $error("motor not extending while extending");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// Expected contents of one result beat, in the order of the result ports.
	typedef struct packed {
		rers_pkg::arm_state_t  arm_state;
		rers_pkg::drive_mode_t mode;
		logic        direction;
		logic [7:0]  pwm;
		logic        detect;
		logic [15:0] distance;
		logic [31:0] extend_cnt;
		logic [31:0] retract_cnt;
		logic [31:0] timer;
	} arm_status_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                 req_valid;
	logic                 req_stall;
	logic [1:0]           req_type;
	logic [1:0]           command_code;
	logic [15:0]          elapsed_ms;
	logic                 home_switch_level;
	logic                 range_ready;
	logic [15:0]          range_sample_mm;

	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [1:0]           bridge_state;
	logic [1:0]           motor_mode;
	logic                 motor_direction;
	logic [7:0]           motor_pwm;
	logic                 object_detected;
	logic [15:0]          distance_mm;
	logic [31:0]          extend_total;
	logic [31:0]          retract_total;
	logic [31:0]          state_time_ms;

	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [rers_pkg::AddrWidth-1:0] paddr;
	logic [rers_pkg::DataWidth-1:0] pwdata;
	logic [rers_pkg::DataWidth-1:0] prdata;
	logic                           pready;

	rack_extend_retract_sequencer dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.req_type          (req_type),
		.command_code      (command_code),
		.elapsed_ms        (elapsed_ms),
		.home_switch_level (home_switch_level),
		.range_ready       (range_ready),
		.range_sample_mm   (range_sample_mm),
		.rsp_valid         (rsp_valid),
		.rsp_stall         (rsp_stall),
		.bridge_state      (bridge_state),
		.motor_mode        (motor_mode),
		.motor_direction   (motor_direction),
		.motor_pwm         (motor_pwm),
		.object_detected   (object_detected),
		.distance_mm       (distance_mm),
		.extend_total      (extend_total),
		.retract_total     (retract_total),
		.state_time_ms     (state_time_ms),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	// The clock period is 12 ns, high and low for 6 ns each.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Our own copy of the sequencer state and of its configuration registers.
	rers_pkg::cfg_t        cfg_shadow;
	rers_pkg::arm_state_t  arm_state;
	logic                  pending_valid;
	rers_pkg::cmd_code_t   pending_cmd;
	rers_pkg::drive_mode_t drive_mode;
	logic [31:0]           state_timer;
	logic [15:0]           last_distance;
	logic                  detect_flag;
	logic [31:0]           extend_tally;
	logic [31:0]           retract_tally;

	// Result beats that the sequencer still owes us, oldest first.
	arm_status_t expected_status[$];

	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	// Changing state always restarts the time in state; staying put leaves it alone.
	task automatic enter_state(input rers_pkg::arm_state_t next);
		if (arm_state != next) begin
			arm_state = next;
			state_timer = '0;
		end
	endtask

	// Applies one request beat to the shadow state and queues the result beat it produces.
	task automatic advance_sequencer(input rers_pkg::request_t r);
		logic [32:0] timer_sum;
		arm_status_t status;
		case (r.req)
			rers_pkg::REQ_TICK: begin
				// The timer saturates instead of wrapping.
				timer_sum = {1'b0, state_timer} + {17'd0, r.elapsed};
				state_timer = timer_sum[32] ? '1 : timer_sum[31:0];
				if (!cfg_shadow.sensor_enable) begin
					last_distance = '0;
					detect_flag = 1'b0;
				end else if (r.range_ready) begin
					last_distance = r.range_sample;
				end
				// The pending command acts before the per-state logic runs, so a command
				// transition restarts the timer ahead of the timeout compares below.
				if (pending_valid) begin
					case (pending_cmd)
						rers_pkg::CMD_EXTEND: begin
							if (arm_state == rers_pkg::ST_STOWED)
								enter_state(rers_pkg::ST_EXTENDING);
						end
						rers_pkg::CMD_RETRACT: begin
							if (arm_state == rers_pkg::ST_EXTENDED ||
									arm_state == rers_pkg::ST_EXTENDING)
								enter_state(rers_pkg::ST_RETRACTING);
						end
						default: begin
							drive_mode = rers_pkg::MODE_OFF;
							enter_state(rers_pkg::ST_STOWED);
						end
					endcase
					pending_valid = 1'b0;
				end
				case (arm_state)
					rers_pkg::ST_STOWED: drive_mode = rers_pkg::MODE_OFF;
					rers_pkg::ST_EXTENDING: begin
						// On a timeout the motor keeps extending until the next tick.
						drive_mode = rers_pkg::MODE_EXTEND;
						if (state_timer >= cfg_shadow.extend_timeout) begin
							extend_tally = extend_tally + 32'd1;
							enter_state(rers_pkg::ST_EXTENDED);
						end
					end
					rers_pkg::ST_EXTENDED: begin
						drive_mode = rers_pkg::MODE_OFF;
						detect_flag = cfg_shadow.sensor_enable && last_distance != '0 &&
							last_distance < cfg_shadow.detect_thresh;
					end
					default: begin
						// The home switch is active low and wins over the safety timeout.
						if (!r.home_level) begin
							drive_mode = rers_pkg::MODE_OFF;
							retract_tally = retract_tally + 32'd1;
							enter_state(rers_pkg::ST_STOWED);
						end else begin
							drive_mode = rers_pkg::MODE_RETRACT;
							if (state_timer >= cfg_shadow.retract_timeout) begin
								retract_tally = retract_tally + 32'd1;
								enter_state(rers_pkg::ST_STOWED);
							end
						end
					end
				endcase
			end
			rers_pkg::REQ_COMMAND: begin
				// A rejected command leaves the pending slot as it was.
				case (r.cmd)
					rers_pkg::CMD_EXTEND: begin
						if (arm_state == rers_pkg::ST_STOWED ||
								arm_state == rers_pkg::ST_EXTENDED) begin
							pending_cmd = rers_pkg::CMD_EXTEND;
							pending_valid = 1'b1;
						end
					end
					rers_pkg::CMD_RETRACT: begin
						if (arm_state == rers_pkg::ST_EXTENDED ||
								arm_state == rers_pkg::ST_EXTENDING) begin
							pending_cmd = rers_pkg::CMD_RETRACT;
							pending_valid = 1'b1;
						end
					end
					default: begin
						pending_cmd = rers_pkg::CMD_STOW;
						pending_valid = 1'b1;
					end
				endcase
			end
			default: begin
				// Pause keeps the pending slot; a reset request also clears it and the counters.
				drive_mode = rers_pkg::MODE_OFF;
				enter_state(rers_pkg::ST_STOWED);
				if (r.req == rers_pkg::REQ_RESET) begin
					pending_valid = 1'b0;
					extend_tally = '0;
					retract_tally = '0;
				end
			end
		endcase
		status.arm_state   = arm_state;
		status.mode        = drive_mode;
		status.direction   = drive_mode == rers_pkg::MODE_EXTEND;
		status.pwm         = drive_mode == rers_pkg::MODE_OFF ? 8'd0 : cfg_shadow.motor_duty;
		status.detect      = detect_flag;
		status.distance    = last_distance;
		status.extend_cnt  = extend_tally;
		status.retract_cnt = retract_tally;
		status.timer       = state_timer;
		expected_status.push_back(status);
	endtask

	// Prints one line per mismatch and counts every one. Printing stops after a hundred
	// lines so that a badly broken block does not flood the log; counting goes on.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 100)
			$display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// Sends one request beat and holds it until the sequencer accepts it. The beat is
	// predicted at the edge where it is taken. Afterwards the sender may go idle for a
	// while; valid is lowered here or in wait_until_idle and only raised at the start of
	// the next call, never both in one time step.
	task automatic send_request(input rers_pkg::req_code_t kind,
			input rers_pkg::cmd_code_t cmd, input logic [15:0] elapsed, input logic home,
			input logic ready, input logic [15:0] sample);
		rers_pkg::request_t r;
		int gap;
		r.req          = kind;
		r.cmd          = cmd;
		r.elapsed      = elapsed;
		r.home_level   = home;
		r.range_ready  = ready;
		r.range_sample = sample;
		req_valid         <= 1'b1;
		req_type          <= r.req;
		command_code      <= r.cmd;
		elapsed_ms        <= r.elapsed;
		home_switch_level <= r.home_level;
		range_ready       <= r.range_ready;
		range_sample_mm   <= r.range_sample;
		do
			@(posedge clk);
		while (req_stall);
		advance_sequencer(r);
		gap = 0;
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
			gap++;
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lowers valid and waits until every owed result beat has come out, then waits on as
	// a margin for the two-stage pipeline.
	task automatic wait_until_idle();
		req_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// A write on the configuration port with a setup and an access phase; pready is always
	// high, so the register takes the value at the edge that ends the access cycle.
	task automatic write_register(input rers_pkg::reg_index_t index,
			input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (index)
			rers_pkg::REG_EXTEND_TIMEOUT:  cfg_shadow.extend_timeout  = value;
			rers_pkg::REG_RETRACT_TIMEOUT: cfg_shadow.retract_timeout = value;
			rers_pkg::REG_DETECT_THRESH:   cfg_shadow.detect_thresh   = value[15:0];
			rers_pkg::REG_MOTOR_DUTY:      cfg_shadow.motor_duty      = value[7:0];
			default:                       cfg_shadow.sensor_enable   = value[0];
		endcase
	endtask

	task automatic configure(input logic [31:0] ext_to, input logic [31:0] ret_to,
			input logic [15:0] thresh, input logic [7:0] duty, input logic enable);
		write_register(rers_pkg::REG_EXTEND_TIMEOUT, ext_to);
		write_register(rers_pkg::REG_RETRACT_TIMEOUT, ret_to);
		write_register(rers_pkg::REG_DETECT_THRESH, {16'd0, thresh});
		write_register(rers_pkg::REG_MOTOR_DUTY, {24'd0, duty});
		write_register(rers_pkg::REG_SENSOR_ENABLE, {31'd0, enable});
	endtask

	// Random traffic that mostly walks the arm through full extend/retract cycles:
	// commands usually suit the current state, elapsed times are mostly short compared
	// with the timeouts, and the home switch closes now and then while retracting.
	// Pauses, reset requests, rejected commands and full-range values are mixed in.
	task automatic run_random_items(input int count);
		int pick;
		rers_pkg::req_code_t kind;
		rers_pkg::cmd_code_t cmd;
		logic [15:0] elapsed;
		logic [15:0] sample;
		logic home;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 58)
				kind = rers_pkg::REQ_TICK;
			else if (pick < 88)
				kind = rers_pkg::REQ_COMMAND;
			else if (pick < 94)
				kind = rers_pkg::REQ_PAUSE;
			else
				kind = rers_pkg::REQ_RESET;
			if ($urandom_range(1) == 0) begin
				case (arm_state)
					rers_pkg::ST_STOWED:     cmd = rers_pkg::CMD_EXTEND;
					rers_pkg::ST_RETRACTING: cmd = $urandom_range(1) ?
						rers_pkg::CMD_STOW : rers_pkg::CMD_STOW_ALT;
					default:                 cmd = rers_pkg::CMD_RETRACT;
				endcase
			end else begin
				cmd = rers_pkg::cmd_code_t'(2'($urandom_range(3)));
			end
			pick = $urandom_range(99);
			if (pick < 70)
				elapsed = 16'($urandom_range(400));
			else if (pick < 90)
				elapsed = 16'($urandom_range(4000));
			else
				elapsed = 16'($urandom);
			if (arm_state == rers_pkg::ST_RETRACTING)
				home = $urandom_range(99) >= 20;
			else
				home = 1'($urandom_range(1));
			pick = $urandom_range(99);
			if (pick < 20)
				sample = '0;
			else if (pick < 60)
				sample = 16'($urandom_range(200));
			else
				sample = 16'($urandom);
			send_request(kind, cmd, elapsed, home, 1'($urandom_range(1)), sample);
		end
	endtask

	task automatic test_motion_sequence();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		// Default registers, sensor disabled: a ready sample must be dropped.
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b1, 16'hFFFF);
		// Retract is rejected while stowed.
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_RETRACT, 16'hFFFF, 1'b0, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		// The command transition on this tick restarts the timer despite the elapsed time.
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd999, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd999, 1'b1, 1'b0, 16'd0);
		// Reaching the timeout exactly ends the extension with the motor still running.
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b0, 16'd0);
		// Extend is latched while extended but does nothing at the tick.
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd5, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_RETRACT, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd0, 1'b1, 1'b0, 16'd0);
		// Retracting ends on the safety timeout with the switch open.
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'hFFFF, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd0, 1'b0, 1'b0, 16'd0);
		// A pause keeps the pending extend, which then acts at the next tick.
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_PAUSE, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_EXTEND, 16'd7, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_STOW_ALT, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd3, 1'b1, 1'b0, 16'd0);
		// Retract from extending, then the closed home switch ends it at once.
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd10, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_RETRACT, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd10, 1'b0, 1'b0, 16'd0);
		// A reset request drops the pending extend and clears both counters.
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_RESET, rers_pkg::CMD_STOW, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd20, 1'b1, 1'b0, 16'd0);
		wait_until_idle();
	endtask

	task automatic test_object_detect();
		write_register(rers_pkg::REG_SENSOR_ENABLE, 32'd1);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd0, 1'b1, 1'b1, 16'd50);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd2000, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1000, 1'b1, 1'b0, 16'd0);
		// Inside the band, at the threshold, just below it, and a zero sample.
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b1, 16'd50);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b1, 16'd100);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b1, 16'd99);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b1, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b1, 16'd1);
		// No new sample: the stored one is used again.
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b0, 16'hFFFF);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_STOW, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b0, 16'd0);
		wait_until_idle();
		// Turning the sensor off clears the distance and the flag at the next tick.
		write_register(rers_pkg::REG_SENSOR_ENABLE, 32'd0);
		send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'd1, 1'b1, 1'b1, 16'd40);
		wait_until_idle();
	endtask

	// With both timeouts at their maximum the arm keeps extending across a run of the
	// longest ticks, and the time in state keeps growing without ending the move.
	task automatic test_long_timeouts();
		configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd100, 8'd128, 1'b0);
		send_request(rers_pkg::REQ_RESET, rers_pkg::CMD_STOW, 16'd0, 1'b1, 1'b0, 16'd0);
		send_request(rers_pkg::REQ_COMMAND, rers_pkg::CMD_EXTEND, 16'd0, 1'b1, 1'b0, 16'd0);
		for (int i = 0; i < 8; i++)
			send_request(rers_pkg::REQ_TICK, rers_pkg::CMD_STOW, 16'hFFFF, 1'b1, 1'b0, 16'd0);
		wait_until_idle();
	endtask

	task automatic test_random_no_idle();
		configure(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		run_random_items(175);
		wait_until_idle();
	endtask

	task automatic test_random_sender_gaps();
		configure($urandom_range(3000), $urandom_range(5000), 16'($urandom_range(400)),
			8'($urandom), 1'b1);
		sender_idle_pct = 65;
		receiver_stall_pct = 0;
		run_random_items(175);
		wait_until_idle();
	endtask

	task automatic test_random_receiver_stall();
		configure(32'd500, 32'd0, 16'd0, 8'd0, 1'b0);
		sender_idle_pct = 0;
		receiver_stall_pct = 65;
		run_random_items(175);
		wait_until_idle();
	endtask

	task automatic test_random_both_idle();
		configure($urandom_range(2000), $urandom_range(3000), 16'($urandom),
			8'($urandom), 1'b1);
		sender_idle_pct = 9;
		receiver_stall_pct = 9;
		run_random_items(175);
		wait_until_idle();
	endtask

	// The receiver stalls at random, independent of whether a beat is on offer.
	always @(posedge clk) begin
		rsp_stall <= receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct;
	end

	// Each result beat taken at an edge is compared field by field with the oldest
	// outstanding prediction. Values read here are the ones from before the edge.
	always @(posedge clk) begin : result_check
		arm_status_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_status.size() == 0) begin
				report_mismatch("result beat with nothing expected, bridge_state",
					{30'd0, bridge_state}, 32'd0);
			end else begin
				want = expected_status.pop_front();
				compare_field("bridge_state", {30'd0, bridge_state}, {30'd0, want.arm_state});
				compare_field("motor_mode", {30'd0, motor_mode}, {30'd0, want.mode});
				compare_field("motor_direction", {31'd0, motor_direction},
					{31'd0, want.direction});
				compare_field("motor_pwm", {24'd0, motor_pwm}, {24'd0, want.pwm});
				compare_field("object_detected", {31'd0, object_detected},
					{31'd0, want.detect});
				compare_field("distance_mm", {16'd0, distance_mm}, {16'd0, want.distance});
				compare_field("extend_total", extend_total, want.extend_cnt);
				compare_field("retract_total", retract_total, want.retract_cnt);
				compare_field("state_time_ms", state_time_ms, want.timer);
			end
		end
	end

	initial begin
		arst_n            <= 1'b0;
		req_valid         <= 1'b0;
		req_type          <= rers_pkg::REQ_TICK;
		command_code      <= rers_pkg::CMD_EXTEND;
		elapsed_ms        <= '0;
		home_switch_level <= 1'b1;
		range_ready       <= 1'b0;
		range_sample_mm   <= '0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		rsp_stall         <= 1'b0;

		cfg_shadow.extend_timeout  = rers_pkg::ExtendTimeoutReset;
		cfg_shadow.retract_timeout = rers_pkg::RetractTimeoutReset;
		cfg_shadow.detect_thresh   = rers_pkg::DetectThreshReset;
		cfg_shadow.motor_duty      = rers_pkg::MotorDutyReset;
		cfg_shadow.sensor_enable   = 1'b0;
		arm_state     = rers_pkg::ST_STOWED;
		pending_valid = 1'b0;
		pending_cmd   = rers_pkg::CMD_EXTEND;
		drive_mode    = rers_pkg::MODE_OFF;
		state_timer   = '0;
		last_distance = '0;
		detect_flag   = 1'b0;
		extend_tally  = '0;
		retract_tally = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_motion_sequence();
		test_object_detect();
		test_long_timeouts();
		test_random_no_idle();
		test_random_sender_gaps();
		test_random_receiver_stall();
		test_random_both_idle();

		wait_until_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_status.size() == 0)
			$display("rack_extend_retract_sequencer test passed");
		else
			$display("rack_extend_retract_sequencer test failed");
		$finish;
	end

	// The whole run finishes well before this deadline even at its slowest;
	// this fires only if a handshake hangs.
	initial begin : watchdog
		#20_000_000;
		$display("rack_extend_retract_sequencer test failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/rers_pkg.sv
hw/rtl/rers_cfg_regs.sv
hw/rtl/rers_step.sv
hw/rtl/rack_extend_retract_sequencer.sv
bench/testbench.sv
